>>> sv/pol_pkg.sv
// Shared types and codes for the positional ordered list.
`default_nettype none

package pol_pkg;

   localparam int OP_W   = 3;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 6;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 6;

   // request word layout, lowest bits first
   localparam int REQ_DATA_W = 48;
   localparam int REQ_OP_LO  = 0;
   localparam int REQ_VAL_LO = REQ_OP_LO + OP_W;
   localparam int REQ_POS_LO = REQ_VAL_LO + VAL_W;

   // response word layout, lowest bits first
   localparam int RSP_DATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND   = 3'd0,
      OP_INSERT   = 3'd1,
      OP_DEL_TAIL = 3'd2,
      OP_DEL_AT   = 3'd3,
      OP_COUNT    = 3'd4,
      OP_DUMP     = 3'd5
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_DUMP
   } state_type;

   typedef logic [OCC_W-1:0] occ_type;

   // one result handed from the sequencer to the output register
   typedef struct packed {
      logic               load;
      status_type         status;
      occ_type            occupancy;
      logic [VAL_W-1:0]   element;
      logic               element_valid;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/pol_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
`default_nettype none

module pol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/pol_seq.sv
// List sequencer: fill count, entry memory and the shift / dump walks.
`default_nettype none

module pol_seq #(
   parameter int DEPTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [pol_pkg::OP_W-1:0]     req_op,
   input  wire logic [pol_pkg::VAL_W-1:0]    req_value,
   input  wire logic [pol_pkg::POS_W-1:0]    req_position,
   input  wire logic                         out_free,
   output pol_pkg::rsp_type                  rsp
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W) + 1;

   typedef logic [AW-1:0]   addr_type;
   typedef logic [CW-1:0]   cnt_type;
   typedef logic [CMPW-1:0] cmp_type;

   pol_pkg::state_type state_ff, state_in;
   cnt_type            count_ff, count_in;
   addr_type           cursor_ff, cursor_in;
   addr_type           target_ff, target_in;
   logic [pol_pkg::VAL_W-1:0] value_ff, value_in;

   logic                      wr_en;
   addr_type                  wr_addr;
   logic [pol_pkg::VAL_W-1:0] wr_data;
   logic                      rd_en;
   addr_type                  rd_addr;
   logic [pol_pkg::VAL_W-1:0] rd_data;

   logic    accept;
   logic    full;
   cmp_type pos_x;
   cmp_type cnt_x;

   pol_ram #(
      .WIDTH (pol_pkg::VAL_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pol_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cursor_ff <= cursor_in;
      target_ff <= target_in;
      value_ff  <= value_in;
   end

   assign req_ready = (state_ff == pol_pkg::S_IDLE) && out_free;
   assign accept    = req_ready && req_valid;
   assign full      = (count_ff == cnt_type'(DEPTH));
   assign pos_x     = cmp_type'(req_position);
   assign cnt_x     = cmp_type'(count_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      target_in = target_ff;
      value_in  = value_ff;
      wr_en     = 1'b0;
      wr_addr   = cursor_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = cursor_ff;
      rsp               = '0;
      rsp.status        = pol_pkg::ST_OK;
      rsp.last          = 1'b1;

      case (state_ff)
         pol_pkg::S_IDLE: begin
            if (accept) begin
               case (req_op)
                  pol_pkg::OP_APPEND: begin
                     rsp.load = 1'b1;
                     if (full) begin
                        rsp.status = pol_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = addr_type'(count_ff);
                        wr_data  = req_value;
                        count_in = count_ff + cnt_type'(1);
                     end
                  end
                  pol_pkg::OP_INSERT: begin
                     if (pos_x == '0 || pos_x > cnt_x + cmp_type'(1)) begin
                        rsp.load   = 1'b1;
                        rsp.status = pol_pkg::ST_RANGE;
                     end else if (full) begin
                        rsp.load   = 1'b1;
                        rsp.status = pol_pkg::ST_FULL;
                     end else if (pos_x == cnt_x + cmp_type'(1)) begin
                        // insert just past the tail: no shift
                        rsp.load = 1'b1;
                        wr_en    = 1'b1;
                        wr_addr  = addr_type'(count_ff);
                        wr_data  = req_value;
                        count_in = count_ff + cnt_type'(1);
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = addr_type'(count_ff - cnt_type'(1));
                        cursor_in = addr_type'(count_ff);
                        target_in = addr_type'(req_position - pol_pkg::POS_W'(1));
                        value_in  = req_value;
                        state_in  = pol_pkg::S_SHIFT_UP;
                     end
                  end
                  pol_pkg::OP_DEL_TAIL: begin
                     rsp.load = 1'b1;
                     if (count_ff == '0) begin
                        rsp.status = pol_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - cnt_type'(1);
                     end
                  end
                  pol_pkg::OP_DEL_AT: begin
                     if (pos_x == '0 || pos_x > cnt_x) begin
                        rsp.load   = 1'b1;
                        rsp.status = pol_pkg::ST_RANGE;
                     end else if (pos_x == cnt_x) begin
                        rsp.load = 1'b1;
                        count_in = count_ff - cnt_type'(1);
                     end else begin
                        // close the gap: copy slot i+1 into slot i upward
                        rd_en     = 1'b1;
                        rd_addr   = addr_type'(req_position);
                        cursor_in = addr_type'(req_position - pol_pkg::POS_W'(1));
                        state_in  = pol_pkg::S_SHIFT_DN;
                     end
                  end
                  pol_pkg::OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp.load = 1'b1;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = '0;
                        cursor_in = '0;
                        state_in  = pol_pkg::S_DUMP;
                     end
                  end
                  default: begin
                     rsp.load = 1'b1;
                  end
               endcase
            end
         end

         pol_pkg::S_SHIFT_UP: begin
            wr_en   = 1'b1;
            wr_addr = cursor_ff;
            if (cursor_ff == target_ff) begin
               wr_data  = value_ff;
               count_in = count_ff + cnt_type'(1);
               rsp.load = 1'b1;
               state_in = pol_pkg::S_IDLE;
            end else begin
               // slot cursor-1 just arrived; fetch cursor-2 for the next copy
               wr_data   = rd_data;
               rd_en     = (cursor_ff - addr_type'(1)) != target_ff;
               rd_addr   = cursor_ff - addr_type'(2);
               cursor_in = cursor_ff - addr_type'(1);
            end
         end

         pol_pkg::S_SHIFT_DN: begin
            wr_en   = 1'b1;
            wr_addr = cursor_ff;
            wr_data = rd_data;
            if (cnt_type'(cursor_ff) + cnt_type'(2) == count_ff) begin
               count_in = count_ff - cnt_type'(1);
               rsp.load = 1'b1;
               state_in = pol_pkg::S_IDLE;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = cursor_ff + addr_type'(2);
               cursor_in = cursor_ff + addr_type'(1);
            end
         end

         pol_pkg::S_DUMP: begin
            // read data stays put while the output register is busy
            if (out_free) begin
               rsp.load          = 1'b1;
               rsp.element       = rd_data;
               rsp.element_valid = 1'b1;
               rsp.last          = (cnt_type'(cursor_ff) + cnt_type'(1) == count_ff);
               if (rsp.last) begin
                  state_in = pol_pkg::S_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = cursor_ff + addr_type'(1);
                  cursor_in = cursor_ff + addr_type'(1);
               end
            end
         end

         default: begin
            state_in = pol_pkg::S_IDLE;
         end
      endcase

      rsp.occupancy = pol_pkg::occ_type'(count_in);
   end

endmodule

`default_nettype wire

>>> sv/positional_ordered_list.sv
// Top level of the positional ordered list: stream ports and response register.
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit values, edited by 1-based
// position. Each request word carries op, value and position; ops are
// append, insert at, delete tail, delete at, count and dump. Every op
// returns one response word (status, occupancy, tlast set), except a dump
// of a non-empty list, which returns one word per value, head first, with
// tuser set on each and tlast on the tail value. Bad positions give status
// 1, delete tail on an empty list status 2, a write to a full list status
// 3; the list is left unchanged in those cases. The values live in one
// RAM with one read and one write port and a registered read, so edits
// walk the entries one per cycle: insert and delete at a position shift
// the entries between that position and the tail, and a dump reads the
// entries in turn from the head, pausing while the response register is
// busy. One request is worked on at a time; a new request is taken once
// the sequencer is idle and the response register is empty or being
// drained. Entries hold no reset value: only slots below the fill count
// are read.
module positional_ordered_list #(
   parameter int DEPTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: op[2:0], value[34:3], position[40:35], zero pad[47:41]
   input  wire logic [pol_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: status[1:0], occupancy[7:2], element[39:8]
   output logic      [pol_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: element_valid[0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);

   pol_pkg::rsp_type rsp;
   logic             out_free;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pol_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                           rsp_user_ff;
   logic                           rsp_last_ff;

   pol_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (req_tdata[pol_pkg::REQ_OP_LO  +: pol_pkg::OP_W]),
      .req_value    (req_tdata[pol_pkg::REQ_VAL_LO +: pol_pkg::VAL_W]),
      .req_position (req_tdata[pol_pkg::REQ_POS_LO +: pol_pkg::POS_W]),
      .out_free     (out_free),
      .rsp          (rsp)
   );

   // response register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp.load) begin
         rsp_data_ff <= {rsp.element, rsp.occupancy, rsp.status};
         rsp_user_ff <= rsp.element_valid;
         rsp_last_ff <= rsp.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
